/* sv/efcrc_pkg.sv */
// ----------------------------------------------------------------------------
// efcrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efcrc_pkg;

	// default payload buffer depth per bank
	localparam int PAYLOAD_DEPTH = 32;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int CRC_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 80;

	// crc constants
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd3;

	// configuration reset values
	localparam logic [BYTE_W-1:0] START_RST = 8'd126;
	localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
	localparam logic [BYTE_W-1:0] MASK_RST = 8'd32;
	localparam logic [LEN_W-1:0]  LIMIT_RST = 6'd32;

	// finished frame descriptor, front to back
	typedef struct packed {
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] seq;
		logic [LEN_W-1:0]  length;
		logic              good;
		logic [CRC_W-1:0]  crc_computed;
		logic [CRC_W-1:0]  crc_received;
		logic              bank;
	} desc_t;

	// queue status toward the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// crc-16/modbus update by one byte, lsb first
	function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/efcrc_ram.sv */
// ----------------------------------------------------------------------------
// efcrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module efcrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/efcrc_front.sv */
// ----------------------------------------------------------------------------
// efcrc_front
// Accepts raw bytes, removes escapes, parses the header, runs the CRC,
// writes payload bytes into the current bank and posts a descriptor per completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module efcrc_front #(
	parameter int PAYLOAD_DEPTH = efcrc_pkg::PAYLOAD_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [efcrc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [efcrc_pkg::BYTE_W-1:0]       cfg_wdata,
	// byte input
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [efcrc_pkg::BYTE_W-1:0]       in_byte,
	// payload ram write
	output logic                                    ram_we,
	output logic [$clog2(2*PAYLOAD_DEPTH)-1:0]      ram_waddr,
	output logic [efcrc_pkg::BYTE_W-1:0]            ram_wdata,
	// descriptor queue
	input  wire efcrc_pkg::q_status_t               q_status,
	output logic                                    q_push,
	output efcrc_pkg::desc_t                        q_desc
);

	localparam int AW = $clog2(2*PAYLOAD_DEPTH);
	localparam logic [efcrc_pkg::LEN_W-1:0] DEPTH_LEN = efcrc_pkg::LEN_W'(PAYLOAD_DEPTH);

	typedef enum logic [2:0] {
		PH_WAIT, PH_ADDR, PH_TYPE, PH_SEQ, PH_LEN, PH_PAY, PH_CRCL, PH_CRCH
	} phase_t;

	phase_t                            phase_q;
	logic                              esc_q;
	logic [efcrc_pkg::BYTE_W-1:0]      start_q, escb_q, mask_q;
	logic [efcrc_pkg::LEN_W-1:0]       limit_q;
	logic [efcrc_pkg::BYTE_W-1:0]      addr_q, type_q, seq_q, crc_lo_q;
	logic [efcrc_pkg::LEN_W-1:0]       len_q, count_q;
	logic [efcrc_pkg::CRC_W-1:0]       crc_q;
	logic                              bank_q;

	logic                              accept, is_start, is_esc, process;
	logic [efcrc_pkg::BYTE_W-1:0]      data;
	logic [efcrc_pkg::LEN_W-1:0]       limit_eff, count_nxt;
	logic [efcrc_pkg::CRC_W-1:0]       crc_nxt, recv;

	// byte classification
	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign is_start  = (in_byte == start_q);
	assign is_esc    = (in_byte == escb_q);
	assign process   = accept && !is_start && (phase_q != PH_WAIT) && (esc_q || !is_esc);
	assign data      = esc_q ? (in_byte ^ mask_q) : in_byte;
	assign crc_nxt   = efcrc_pkg::crc_add(crc_q, data);
	assign limit_eff = (limit_q > DEPTH_LEN) ? DEPTH_LEN : limit_q;
	assign count_nxt = count_q + efcrc_pkg::LEN_W'(1);
	assign recv      = {data, crc_lo_q};

	// payload write into current bank
	assign ram_we    = process && (phase_q == PH_PAY);
	assign ram_waddr = bank_q ? (AW'(PAYLOAD_DEPTH) + AW'(count_q)) : AW'(count_q);
	assign ram_wdata = data;

	// descriptor of the finished frame
	assign q_push              = process && (phase_q == PH_CRCH);
	assign q_desc.addr         = addr_q;
	assign q_desc.ftype        = type_q;
	assign q_desc.seq          = seq_q;
	assign q_desc.length       = len_q;
	assign q_desc.good         = (crc_q == recv);
	assign q_desc.crc_computed = crc_q;
	assign q_desc.crc_received = recv;
	assign q_desc.bank         = bank_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= efcrc_pkg::START_RST;
			escb_q  <= efcrc_pkg::ESCAPE_RST;
			mask_q  <= efcrc_pkg::MASK_RST;
			limit_q <= efcrc_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				efcrc_pkg::CFG_START_BYTE:    start_q <= cfg_wdata;
				efcrc_pkg::CFG_ESCAPE_BYTE:   escb_q  <= cfg_wdata;
				efcrc_pkg::CFG_ESCAPE_MASK:   mask_q  <= cfg_wdata;
				efcrc_pkg::CFG_PAYLOAD_LIMIT: limit_q <= cfg_wdata[efcrc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			esc_q    <= 1'b0;
			count_q  <= '0;
			crc_q    <= efcrc_pkg::CRC_INIT;
			bank_q   <= 1'b0;
			addr_q   <= '0;
			type_q   <= '0;
			seq_q    <= '0;
			len_q    <= '0;
			crc_lo_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				phase_q <= PH_ADDR;
				esc_q   <= 1'b0;
				count_q <= '0;
				crc_q   <= efcrc_pkg::CRC_INIT;
			end else if (phase_q != PH_WAIT) begin
				if (!esc_q && is_esc) begin
					esc_q <= 1'b1;
				end else begin
					esc_q <= 1'b0;
					case (phase_q)
						PH_ADDR: begin
							addr_q  <= data;
							crc_q   <= crc_nxt;
							phase_q <= PH_TYPE;
						end
						PH_TYPE: begin
							type_q  <= data;
							crc_q   <= crc_nxt;
							phase_q <= PH_SEQ;
						end
						PH_SEQ: begin
							seq_q   <= data;
							crc_q   <= crc_nxt;
							phase_q <= PH_LEN;
						end
						PH_LEN: begin
							if (data > {2'b00, limit_eff}) begin
								count_q <= '0;
								crc_q   <= efcrc_pkg::CRC_INIT;
								phase_q <= PH_WAIT;
							end else begin
								len_q   <= data[efcrc_pkg::LEN_W-1:0];
								crc_q   <= crc_nxt;
								phase_q <= (data[efcrc_pkg::LEN_W-1:0] == '0) ? PH_CRCL : PH_PAY;
							end
						end
						PH_PAY: begin
							count_q <= count_nxt;
							crc_q   <= crc_nxt;
							if (count_nxt >= len_q) begin
								phase_q <= PH_CRCL;
							end
						end
						PH_CRCL: begin
							crc_lo_q <= data;
							phase_q  <= PH_CRCH;
						end
						PH_CRCH: begin
							// frame done, next frame goes to the other bank
							count_q <= '0;
							crc_q   <= efcrc_pkg::CRC_INIT;
							bank_q  <= !bank_q;
							phase_q <= PH_WAIT;
						end
						default: phase_q <= PH_WAIT;
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/efcrc_queue.sv */
// ----------------------------------------------------------------------------
// efcrc_queue
// Two-entry descriptor queue between parser and result emitter. An entry
// stays until its frame is fully emitted, so it also guards its ram bank.
// ----------------------------------------------------------------------------
`default_nettype none

module efcrc_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire efcrc_pkg::desc_t      push_desc,
	input  wire logic                  pop,
	output efcrc_pkg::desc_t           head,
	output efcrc_pkg::q_status_t       status
);

	efcrc_pkg::desc_t entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/efcrc_back.sv */
// ----------------------------------------------------------------------------
// efcrc_back
// Result emitter: walks the payload bank of the head descriptor and drives
// one registered result item per payload byte, or one item for a bad or
// empty frame.
// ----------------------------------------------------------------------------
`default_nettype none

module efcrc_back #(
	parameter int PAYLOAD_DEPTH = efcrc_pkg::PAYLOAD_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// descriptor queue
	input  wire efcrc_pkg::desc_t                   head,
	input  wire efcrc_pkg::q_status_t               q_status,
	output logic                                    q_pop,
	// payload ram read
	output logic [$clog2(2*PAYLOAD_DEPTH)-1:0]      ram_raddr,
	input  wire logic [efcrc_pkg::BYTE_W-1:0]       ram_rdata,
	// result output
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [efcrc_pkg::BYTE_W-1:0]            out_byte,
	output logic [efcrc_pkg::LEN_W-1:0]             out_index,
	output logic                                    out_last
);

	localparam int AW = $clog2(2*PAYLOAD_DEPTH);

	typedef enum logic [1:0] {B_IDLE, B_RD, B_LD, B_OUT} bstate_t;

	bstate_t                      state_q;
	logic [efcrc_pkg::LEN_W-1:0]  idx_q;
	logic                         done;

	assign ram_raddr = head.bank ? (AW'(PAYLOAD_DEPTH) + AW'(idx_q)) : AW'(idx_q);
	assign out_valid = (state_q == B_OUT);
	assign done      = (state_q == B_OUT) && out_ready;
	assign q_pop     = done && out_last;

	// emitter sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			idx_q     <= '0;
			out_byte  <= '0;
			out_index <= '0;
			out_last  <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					if (!q_status.empty) begin
						if (!head.good || (head.length == '0)) begin
							out_byte  <= '0;
							out_index <= '0;
							out_last  <= 1'b1;
							state_q   <= B_OUT;
						end else begin
							state_q <= B_RD;
						end
					end
				end
				B_RD: state_q <= B_LD;
				B_LD: begin
					out_byte  <= ram_rdata;
					out_index <= idx_q;
					out_last  <= ((idx_q + efcrc_pkg::LEN_W'(1)) == head.length);
					state_q   <= B_OUT;
				end
				B_OUT: begin
					if (out_ready) begin
						if (out_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + efcrc_pkg::LEN_W'(1);
							state_q <= B_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/escaped_frame_receiver_crc16_top.sv */
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16_top
// Byte-stuffed frame receiver with CRC-16/MODBUS check; emits the payload
// of good frames byte by byte and one marked item for a bad frame.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------
//  s_       | in  | s_tvalid/s_tready | s_tdata: rx_byte
//  m_       | out | m_tvalid/m_tready | m_tdata, m_tlast: last, m_tuser: crc_good
//  cfg_     | in  | cfg_we            | cfg_addr index, cfg_wdata value
//
//  input bytes are taken in one cycle each while s_tready is high; the parser
//  runs the crc byte update and the payload ram write in the same cycle.
//  a payload item passes the ram read, load and output states, the single
//  item of a bad or empty frame only output; each frame adds the idle state.
//  s_tready drops only while two finished frames still wait for their results.
//  reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver_crc16_top #(
	parameter int PAYLOAD_DEPTH = efcrc_pkg::PAYLOAD_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// byte input
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,   // rx_byte
	// result output
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// frame_addr, frame_type, frame_seq, frame_length, payload_byte,
	// payload_index, crc_computed, crc_received, zero fill
	output logic [efcrc_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic                                     m_tlast,
	output logic                                     m_tuser,   // crc_good
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [efcrc_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [efcrc_pkg::BYTE_W-1:0]        cfg_wdata
);

	localparam int AW = $clog2(2*PAYLOAD_DEPTH);

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr, ram_raddr;
	logic [efcrc_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;
	logic                           q_push, q_pop;
	efcrc_pkg::desc_t               q_desc, q_head;
	efcrc_pkg::q_status_t           q_status;
	logic [efcrc_pkg::BYTE_W-1:0]   out_byte;
	logic [efcrc_pkg::LEN_W-1:0]    out_index;

	// parser
	efcrc_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	// two payload banks
	efcrc_ram #(.WIDTH(efcrc_pkg::BYTE_W), .DEPTH(2*PAYLOAD_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// descriptor queue
	efcrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	// result emitter
	efcrc_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_index (out_index),
		.out_last  (m_tlast)
	);

	// output packing
	assign m_tdata = {4'b0000, q_head.crc_received, q_head.crc_computed, out_index,
		out_byte, q_head.length, q_head.seq, q_head.ftype, q_head.addr};
	assign m_tuser = q_head.good;

	// a bad frame gives a single item
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("bad crc item not marked last");

	// payload index stays below the frame length on non-final items
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[43:38] < m_tdata[29:24]))
		else $error("payload index out of range");

	// an empty frame gives one zero item
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[29:24] == 6'd0) |-> m_tlast && (m_tdata[37:30] == 8'd0))
		else $error("empty frame item malformed");

	// the queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("descriptor queue overflow");

	// a finished frame is released right after its last item is taken
	a_pop_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("emitter did not return to idle after last item");

endmodule

`default_nettype wire

/* tb/escaped_frame_receiver_crc16_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16_top_test
// Drives byte-stuffed frames, broken frames and line noise into the receiver
// under several start/escape/mask/limit settings and idle patterns, predicts
// every result item with an internal frame decoder and compares each one
// field by field as it leaves the block.
// ----------------------------------------------------------------------------

module escaped_frame_receiver_crc16_top_test;

	localparam int BODY_DEPTH    = efcrc_pkg::PAYLOAD_DEPTH;
	localparam int BODY_AW       = $clog2(BODY_DEPTH);
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_GAP       = 60;

	typedef enum logic [2:0] {
		ST_HUNT, ST_ADDR, ST_TYPE, ST_SEQ, ST_LEN, ST_BODY, ST_CRC_LO, ST_CRC_HI
	} rx_state_t;

	typedef enum logic [1:0] {
		IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [7:0]  addr;
		logic [7:0]  ftype;
		logic [7:0]  seq;
		logic [5:0]  length;
		logic [7:0]  pbyte;
		logic [5:0]  pidx;
		logic        last;
		logic        good;
		logic [15:0] crc_calc;
		logic [15:0] crc_rx;
	} frame_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [efcrc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we;
	logic [efcrc_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [7:0]  cfg_wdata;

	// decoder copy of the registers
	logic [7:0]  reg_start;
	logic [7:0]  reg_escape;
	logic [7:0]  reg_mask;
	logic [5:0]  reg_limit;

	// decoder copy of the frame state
	rx_state_t   rx_state;
	logic        esc_armed;
	logic [7:0]  cur_addr;
	logic [7:0]  cur_type;
	logic [7:0]  cur_seq;
	logic [5:0]  cur_len;
	logic [5:0]  body_count;
	logic [7:0]  body_mem [BODY_DEPTH];
	logic [15:0] crc_acc;
	logic [7:0]  crc_lo_seen;

	frame_item_t frame_items_due[$];
	idle_mode_t  idle_mode;
	int          error_count;
	int          bytes_sent;
	int          quiet_cycles;

	escaped_frame_receiver_crc16_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// crc-16/modbus, one byte, reflected
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		r = c ^ {8'h00, d};
		repeat (8) r = r[0] ? ((r >> 1) ^ efcrc_pkg::CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// byte with a bias toward the framing values
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(15);
		if (r == 0) begin
			return reg_start;
		end else if (r == 1) begin
			return reg_escape;
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic frame_restart();
		esc_armed  = 1'b0;
		body_count = '0;
		crc_acc    = efcrc_pkg::CRC_INIT;
	endtask

	task automatic queue_item(input logic [7:0] pbyte, input logic [5:0] pidx,
		input logic last, input logic good, input logic [15:0] crc_rx);
		frame_item_t it;
		it.addr     = cur_addr;
		it.ftype    = cur_type;
		it.seq      = cur_seq;
		it.length   = cur_len;
		it.pbyte    = pbyte;
		it.pidx     = pidx;
		it.last     = last;
		it.good     = good;
		it.crc_calc = crc_acc;
		it.crc_rx   = crc_rx;
		frame_items_due.push_back(it);
	endtask

	// frame decoder: one raw byte in, due result items queued
	task automatic decode_rx_byte(input logic [7:0] raw);
		logic [7:0]  b;
		logic [15:0] crc_rx;
		logic        take;
		int          lim;
		b    = raw;
		take = 1'b0;
		if (raw == reg_start) begin
			frame_restart();
			rx_state = ST_ADDR;
		end else if (rx_state != ST_HUNT) begin
			if (esc_armed) begin
				b         = raw ^ reg_mask;
				esc_armed = 1'b0;
				take      = 1'b1;
			end else if (raw == reg_escape) begin
				esc_armed = 1'b1;
			end else begin
				take = 1'b1;
			end
		end
		if (take) begin
			case (rx_state)
				ST_ADDR: begin
					cur_addr = b;
					crc_acc  = crc16_step(crc_acc, b);
					rx_state = ST_TYPE;
				end
				ST_TYPE: begin
					cur_type = b;
					crc_acc  = crc16_step(crc_acc, b);
					rx_state = ST_SEQ;
				end
				ST_SEQ: begin
					cur_seq  = b;
					crc_acc  = crc16_step(crc_acc, b);
					rx_state = ST_LEN;
				end
				ST_LEN: begin
					lim = (reg_limit > BODY_DEPTH) ? BODY_DEPTH : int'(reg_limit);
					if (int'(b) > lim) begin
						// oversize: drop the frame silently
						frame_restart();
						rx_state = ST_HUNT;
					end else begin
						cur_len  = b[5:0];
						crc_acc  = crc16_step(crc_acc, b);
						rx_state = (b[5:0] == 6'd0) ? ST_CRC_LO : ST_BODY;
					end
				end
				ST_BODY: begin
					if (body_count < BODY_DEPTH) begin
						body_mem[body_count[BODY_AW-1:0]] = b;
					end
					body_count = body_count + 6'd1;
					crc_acc    = crc16_step(crc_acc, b);
					if (body_count >= cur_len) begin
						rx_state = ST_CRC_LO;
					end
				end
				ST_CRC_LO: begin
					crc_lo_seen = b;
					rx_state    = ST_CRC_HI;
				end
				default: begin
					crc_rx = {b, crc_lo_seen};
					if (crc_acc != crc_rx) begin
						queue_item(8'h00, 6'd0, 1'b1, 1'b0, crc_rx);
					end else if (cur_len == 6'd0) begin
						queue_item(8'h00, 6'd0, 1'b1, 1'b1, crc_rx);
					end else begin
						for (int i = 0; i < cur_len; i++) begin
							queue_item(body_mem[i], 6'(i), (i + 1 == cur_len), 1'b1, crc_rx);
						end
					end
					frame_restart();
					rx_state = ST_HUNT;
				end
			endcase
		end
	endtask

	// one byte over the input stream, with random idle before it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 10 : 0;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		decode_rx_byte(b);
		bytes_sent++;
	endtask

	// content byte, escaped when it collides with a framing value and escaping is possible, and now and then at random
	task automatic send_stuffed(input logic [7:0] v);
		logic need;
		logic can;
		need = (v == reg_start) || (v == reg_escape);
		can  = (reg_escape != reg_start) && ((v ^ reg_mask) != reg_start);
		if (can && (need || $urandom_range(15) == 0)) begin
			send_byte(reg_escape);
			send_byte(v ^ reg_mask);
		end else begin
			send_byte(v);
		end
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] ftype,
		input logic [7:0] seq, input logic [7:0] body[$], input logic corrupt);
		logic [15:0] c;
		c = efcrc_pkg::CRC_INIT;
		c = crc16_step(c, addr);
		c = crc16_step(c, ftype);
		c = crc16_step(c, seq);
		c = crc16_step(c, 8'(body.size()));
		foreach (body[i]) c = crc16_step(c, body[i]);
		if (corrupt) begin
			c = c ^ (16'h0001 << $urandom_range(15));
		end
		send_byte(reg_start);
		send_stuffed(addr);
		send_stuffed(ftype);
		send_stuffed(seq);
		send_stuffed(8'(body.size()));
		foreach (body[i]) send_stuffed(body[i]);
		send_stuffed(c[7:0]);
		send_stuffed(c[15:8]);
	endtask

	// hold the input until every due item is out, then let the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (frame_items_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] start_v, input logic [7:0] esc_v,
		input logic [7:0] mask_v, input logic [5:0] limit_v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= efcrc_pkg::CFG_START_BYTE;
		cfg_wdata <= start_v;
		@(posedge clk);
		cfg_addr  <= efcrc_pkg::CFG_ESCAPE_BYTE;
		cfg_wdata <= esc_v;
		@(posedge clk);
		cfg_addr  <= efcrc_pkg::CFG_ESCAPE_MASK;
		cfg_wdata <= mask_v;
		@(posedge clk);
		cfg_addr  <= efcrc_pkg::CFG_PAYLOAD_LIMIT;
		cfg_wdata <= {2'b00, limit_v};
		@(posedge clk);
		cfg_we     <= 1'b0;
		reg_start  = start_v;
		reg_escape = esc_v;
		reg_mask   = mask_v;
		reg_limit  = limit_v;
	endtask

	// mostly well-formed frames, the rest oversize, truncated or noise
	task automatic run_traffic(input int n_items);
		int         stop_at;
		int         lim_eff;
		int         len;
		int         kind;
		logic       first;
		logic [7:0] body[$];
		stop_at = bytes_sent + n_items;
		lim_eff = (reg_limit > BODY_DEPTH) ? BODY_DEPTH : int'(reg_limit);
		first   = 1'b1;
		while (bytes_sent < stop_at) begin
			kind = first ? 0 : $urandom_range(99);
			if (!first && $urandom_range(19) == 0) begin
				wait_drained();
			end
			if (kind < 70) begin
				// first frame of a setting uses the largest length allowed
				if (first) begin
					len = lim_eff;
				end else if ($urandom_range(9) == 0) begin
					len = $urandom_range(lim_eff, 0);
				end else begin
					len = $urandom_range((lim_eff < 8) ? lim_eff : 8, 0);
				end
				body.delete();
				repeat (len) body.push_back(pick_byte());
				send_frame(pick_byte(), pick_byte(), pick_byte(), body,
					!first && $urandom_range(3) == 0);
			end else if (kind < 78) begin
				send_byte(reg_start);
				repeat (3) send_stuffed(pick_byte());
				send_stuffed(8'($urandom_range(255, lim_eff + 1)));
			end else if (kind < 88) begin
				send_byte(reg_start);
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(4, 1)) send_byte(pick_byte());
			end
			first = 1'b0;
		end
	endtask

	task automatic test_special_cases();
		logic [7:0] body[$];
		idle_mode = IDLE_NONE;
		// bytes ahead of any start byte
		send_byte(8'h00);
		send_byte(reg_escape);
		// empty payload
		body.delete();
		send_frame(8'h00, 8'hFF, 8'h00, body, 1'b0);
		// payload bytes that need escaping
		body.push_back(reg_start);
		body.push_back(reg_escape);
		send_frame(8'hFF, 8'h00, 8'hFF, body, 1'b0);
		// bad crc
		body.delete();
		body.push_back(8'hFF);
		send_frame(8'h12, 8'h34, 8'h56, body, 1'b1);
		// length over the limit
		send_byte(reg_start);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'd33);
		// start byte right after an escape restarts the frame
		send_byte(reg_start);
		send_byte(8'h44);
		send_byte(reg_escape);
		body.delete();
		body.push_back(8'h00);
		send_frame(8'hA0, 8'h0B, 8'hC0, body, 1'b0);
	endtask

	task automatic test_extreme_settings();
		program_regs(8'h00, 8'hFF, 8'hFF, 6'd0);
		idle_mode = IDLE_SEND;
		run_traffic(70);
		program_regs(8'hFF, 8'h00, 8'h00, 6'd63);
		idle_mode = IDLE_RECV;
		run_traffic(70);
	endtask

	task automatic test_start_as_escape();
		// start wins when both framing values are the same
		program_regs(8'hA5, 8'hA5, 8'h5A, 6'd5);
		idle_mode = IDLE_NONE;
		run_traffic(60);
	endtask

	task automatic test_random_settings();
		program_regs(8'h7E, 8'h7D, 8'h20, 6'd32);
		idle_mode = IDLE_BOTH;
		run_traffic(70);
		repeat (3) begin
			program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 6'($urandom_range(63)));
			idle_mode = idle_mode_t'($urandom_range(3));
			run_traffic(55);
		end
	endtask

	task automatic check_field(input string fname, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns mismatch %s expected %h actual %h", $time, fname, want, got);
			error_count++;
		end
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 73 :
			(idle_mode == IDLE_BOTH) ? 10 : 0));
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin : result_check
		frame_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_items_due.size() == 0) begin
				$display("%0t ns unexpected result item tdata %h", $time, m_tdata);
				error_count++;
			end else begin
				want = frame_items_due.pop_front();
				check_field("frame_addr", 16'(want.addr), 16'(m_tdata[7:0]));
				check_field("frame_type", 16'(want.ftype), 16'(m_tdata[15:8]));
				check_field("frame_seq", 16'(want.seq), 16'(m_tdata[23:16]));
				check_field("frame_length", 16'(want.length), 16'(m_tdata[29:24]));
				check_field("payload_byte", 16'(want.pbyte), 16'(m_tdata[37:30]));
				check_field("payload_index", 16'(want.pidx), 16'(m_tdata[43:38]));
				check_field("crc_computed", want.crc_calc, m_tdata[59:44]);
				check_field("crc_received", want.crc_rx, m_tdata[75:60]);
				check_field("last", 16'(want.last), 16'(m_tlast));
				check_field("crc_good", 16'(want.good), 16'(m_tuser));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= 8'h00;
		m_tready     <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_addr     <= efcrc_pkg::CFG_START_BYTE;
		cfg_wdata    <= 8'h00;
		quiet_cycles <= 0;
		idle_mode    = IDLE_NONE;
		error_count  = 0;
		bytes_sent   = 0;
		reg_start    = efcrc_pkg::START_RST;
		reg_escape   = efcrc_pkg::ESCAPE_RST;
		reg_mask     = efcrc_pkg::MASK_RST;
		reg_limit    = efcrc_pkg::LIMIT_RST;
		rx_state     = ST_HUNT;
		cur_addr     = 8'h00;
		cur_type     = 8'h00;
		cur_seq      = 8'h00;
		cur_len      = 6'd0;
		crc_lo_seen  = 8'h00;
		frame_restart();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_extreme_settings();
		test_start_as_escape();
		test_random_settings();

		wait_drained();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
